[rtl/idsd_pkg.sv]
`default_nettype none

package idsd_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned DnumW  = 23;  // day number, year offset by 400
  localparam int unsigned CountW = 22;

  localparam logic [MonthW-1:0] MonJan = 4'd1;
  localparam logic [MonthW-1:0] MonFeb = 4'd2;
  localparam logic [MonthW-1:0] MonMar = 4'd3;
  localparam logic [MonthW-1:0] MonDec = 4'd12;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  typedef logic [DnumW-1:0] dnum_t;

  // days before the 1st of each month, counted from March 1
  function automatic logic [8:0] month_offset(input logic [MonthW-1:0] m);
    logic [8:0] r;
    unique case (m)
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      default: r = 9'd275;
    endcase
    return r;
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] r;
    unique case (m)
      4'd2:                      r = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction

  function automatic logic [MonthW-1:0] fix_month(input logic [MonthW-1:0] m);
    logic [MonthW-1:0] r;
    if (m < MonJan) begin
      r = MonJan;
    end else if (m > MonDec) begin
      r = MonDec;
    end else begin
      r = m;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/inclusive_date_span_days.sv]
`default_nettype none

// Inclusive Gregorian date span.
// Input channel (in_valid/in_ready) carries a start date and an optional end
// date; with end_given low the end is the last day of the start month.
// Output channel (out_valid/out_ready) returns day_count, both ends counted,
// or 0 with order_error set when the end lies before the start.
// Three register stages: input register, day-number register, result
// register, passed in that order on the way to out_valid.
// One item per cycle while out_ready is high; each stage moves whenever the
// stage after it is empty or moving, so bubbles are squeezed out.
// When the receiver stalls, the result holds and the stages behind it fill;
// in_ready drops once all three stages hold an item.
// Counts above 4194303 saturate there.
// Reset empties all stages; no item is lost or repeated across a stall.
module inclusive_date_span_days (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire logic [idsd_pkg::YearW-1:0]   start_year,
  input  wire logic [idsd_pkg::MonthW-1:0]  start_month,
  input  wire logic [idsd_pkg::DayW-1:0]    start_day,
  input  wire logic                         end_given,
  input  wire logic [idsd_pkg::YearW-1:0]   end_year,
  input  wire logic [idsd_pkg::MonthW-1:0]  end_month,
  input  wire logic [idsd_pkg::DayW-1:0]    end_day,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      logic [idsd_pkg::CountW-1:0]  day_count,
  output      logic                         order_error
);

  // stage 0: input register
  logic                          v0;
  logic [idsd_pkg::YearW-1:0]    sy0, ey0;
  logic [idsd_pkg::MonthW-1:0]   sm0, em0;
  logic [idsd_pkg::DayW-1:0]     sd0, ed0;
  logic                          eg0;

  // stage 1: day numbers
  logic                          v1;
  idsd_pkg::dnum_t               s1, e1;

  logic en0, en1, en2;

  assign en2      = !out_valid || out_ready;
  assign en1      = !v1 || en2;
  assign en0      = !v0 || en1;
  assign in_ready = en0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en0) begin
      v0 <= in_valid;
    end
    if (en0 && in_valid) begin
      sy0 <= start_year;
      sm0 <= start_month;
      sd0 <= start_day;
      eg0 <= end_given;
      ey0 <= end_year;
      em0 <= end_month;
      ed0 <= end_day;
    end
  end

  logic [idsd_pkg::MonthW-1:0] smf, emf, em_sel;
  logic [idsd_pkg::YearW-1:0]  ey_sel;
  logic [idsd_pkg::DayW-1:0]   ed_sel;
  idsd_pkg::dnum_t             s_num, e_num;

  always_comb begin
    smf = idsd_pkg::fix_month(sm0);
    emf = idsd_pkg::fix_month(em0);
    if (eg0) begin
      ey_sel = ey0;
      em_sel = emf;
      ed_sel = ed0;
    end else if (smf == idsd_pkg::MonFeb) begin
      // last day of February is "day 0" of March, leap or not
      ey_sel = sy0;
      em_sel = idsd_pkg::MonMar;
      ed_sel = '0;
    end else begin
      ey_sel = sy0;
      em_sel = smf;
      ed_sel = idsd_pkg::month_len(smf);
    end
  end

  idsd_day_num u_start (
    .year  (sy0),
    .month (smf),
    .day   (sd0),
    .dnum  (s_num)
  );

  idsd_day_num u_end (
    .year  (ey_sel),
    .month (em_sel),
    .day   (ed_sel),
    .dnum  (e_num)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= v0;
    end
    if (en1 && v0) begin
      s1 <= s_num;
      e1 <= e_num;
    end
  end

  // stage 2: difference, saturation
  logic [idsd_pkg::DnumW:0]    span;
  logic [idsd_pkg::CountW-1:0] count_next;
  logic                        err_next;

  always_comb begin
    span     = {1'b0, e1} - {1'b0, s1} + 24'd1;
    err_next = (e1 < s1);
    if (err_next) begin
      count_next = '0;
    end else if (span > 24'(idsd_pkg::CountMax)) begin
      count_next = idsd_pkg::CountMax;
    end else begin
      count_next = span[idsd_pkg::CountW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en2) begin
      out_valid <= v1;
    end
    if (en2 && v1) begin
      day_count   <= count_next;
      order_error <= err_next;
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && order_error) |-> (day_count == '0))
    else $error("order error with nonzero count");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !order_error) |-> (day_count != '0))
    else $error("ordered dates gave zero count");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (v0 && v1 && out_valid && !out_ready))
    else $error("input stalled while pipeline not full");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v0)
    else $error("accepted item missing from input stage");

endmodule

`default_nettype wire

[rtl/idsd_day_num.sv]
`default_nettype none

// Closed-form day number with a March-based year.
module idsd_day_num (
  input  wire logic [idsd_pkg::YearW-1:0]  year,
  input  wire logic [idsd_pkg::MonthW-1:0] month,
  input  wire logic [idsd_pkg::DayW-1:0]   day,
  output idsd_pkg::dnum_t                  dnum
);

  // floor(x/25) = (x * 41944) >> 20, exact for x below 43690
  localparam logic [15:0] Recip25 = 16'd41944;

  logic [14:0] yy;
  logic [12:0] q4;
  logic [27:0] prod;
  logic [7:0]  q100;
  logic [5:0]  q400;

  always_comb begin
    yy   = 15'(year) + 15'd400 - ((month <= idsd_pkg::MonFeb) ? 15'd1 : 15'd0);
    q4   = yy[14:2];
    prod = 28'(q4) * 28'(Recip25);
    q100 = prod[27:20];
    q400 = q100[7:2];
    dnum = idsd_pkg::DnumW'(yy * 23'd365) + idsd_pkg::DnumW'(q4)
         - idsd_pkg::DnumW'(q100) + idsd_pkg::DnumW'(q400)
         + idsd_pkg::DnumW'(idsd_pkg::month_offset(month))
         + idsd_pkg::DnumW'(day);
  end

endmodule

`default_nettype wire

[tb/sv/inclusive_date_span_days_test.sv]
`default_nettype none

module inclusive_date_span_days_test;

  typedef struct {
    logic [idsd_pkg::CountW-1:0] day_count;
    logic                        order_error;
  } span_t;

  // last day of a month; the year only matters for February
  function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
    int unsigned n;
    case (m)
      2:              n = ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 29 : 28;
      4, 6, 9, 11:    n = 30;
      default:        n = 31;
    endcase
    return n;
  endfunction

  function automatic logic [idsd_pkg::YearW-1:0] rand_year(input int unsigned lo,
                                                          input int unsigned hi);
    int unsigned v;
    v = $urandom_range(lo, hi);
    return v[idsd_pkg::YearW-1:0];
  endfunction

  function automatic logic [idsd_pkg::MonthW-1:0] rand_month(input int unsigned lo,
                                                            input int unsigned hi);
    int unsigned v;
    v = $urandom_range(lo, hi);
    return v[idsd_pkg::MonthW-1:0];
  endfunction

  function automatic logic [idsd_pkg::DayW-1:0] rand_day(input int unsigned lo,
                                                        input int unsigned hi);
    int unsigned v;
    v = $urandom_range(lo, hi);
    return v[idsd_pkg::DayW-1:0];
  endfunction

  function automatic logic rand_bit();
    int unsigned v;
    v = $urandom_range(0, 1);
    return v[0];
  endfunction

  class span_scoreboard;
    span_t spans_due[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int unsigned clamp_month(input logic [idsd_pkg::MonthW-1:0] m);
      int unsigned v;
      v = m;
      if (v < 1) v = 1;
      if (v > 12) v = 12;
      return v;
    endfunction

    // serial day number, March-based year shifted by 400 years
    function longint unsigned day_serial(input int unsigned y, input int unsigned m,
                                         input int unsigned d);
      longint unsigned yr, mp, doy;
      yr = longint'(y) + 400 - ((m <= 2) ? 1 : 0);
      mp = (m + 9) % 12;
      doy = (153 * mp + 2) / 5 + d;
      return yr * 365 + yr / 4 - yr / 100 + yr / 400 + doy;
    endfunction

    function void note_dates(input logic [idsd_pkg::YearW-1:0] sy,
                             input logic [idsd_pkg::MonthW-1:0] sm,
                             input logic [idsd_pkg::DayW-1:0] sd, input logic eg,
                             input logic [idsd_pkg::YearW-1:0] ey,
                             input logic [idsd_pkg::MonthW-1:0] em,
                             input logic [idsd_pkg::DayW-1:0] ed);
      int unsigned s_m, e_y, e_m, e_d;
      longint unsigned s_num, e_num, span;
      span_t r;
      s_m = clamp_month(sm);
      if (eg) begin
        e_y = ey;
        e_m = clamp_month(em);
        e_d = ed;
      end else begin
        e_y = sy;
        e_m = s_m;
        e_d = days_in_month(sy, s_m);
      end
      s_num = day_serial(sy, s_m, sd);
      e_num = day_serial(e_y, e_m, e_d);
      if (e_num < s_num) begin
        r.day_count = '0;
        r.order_error = 1'b1;
      end else begin
        span = e_num - s_num + 1;
        if (span > longint'(idsd_pkg::CountMax)) span = longint'(idsd_pkg::CountMax);
        r.day_count = span[idsd_pkg::CountW-1:0];
        r.order_error = 1'b0;
      end
      spans_due = {spans_due, r};
    endfunction

    function void check_span(input logic [idsd_pkg::CountW-1:0] cnt, input logic err);
      span_t want;
      if (spans_due.size() == 0) begin
        $error("result with nothing pending: day_count %0d order_error %0b", cnt, err);
        mismatches++;
        return;
      end
      want = spans_due.pop_front();
      if (cnt !== want.day_count) begin
        $error("day_count: expected %0d, got %0d", want.day_count, cnt);
        mismatches++;
      end
      if (err !== want.order_error) begin
        $error("order_error: expected %0b, got %0b", want.order_error, err);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return spans_due.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [idsd_pkg::YearW-1:0]    start_year = '0;
  logic [idsd_pkg::MonthW-1:0]   start_month = '0;
  logic [idsd_pkg::DayW-1:0]     start_day = '0;
  logic                          end_given = 1'b0;
  logic [idsd_pkg::YearW-1:0]    end_year = '0;
  logic [idsd_pkg::MonthW-1:0]   end_month = '0;
  logic [idsd_pkg::DayW-1:0]     end_day = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [idsd_pkg::CountW-1:0]   day_count;
  logic                          order_error;

  span_scoreboard sb = new();
  int unsigned items_sent = 0;

  inclusive_date_span_days u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .start_year  (start_year),
    .start_month (start_month),
    .start_day   (start_day),
    .end_given   (end_given),
    .end_year    (end_year),
    .end_month   (end_month),
    .end_day     (end_day),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .day_count   (day_count),
    .order_error (order_error)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #(20 * 400000);
    $display("inclusive_date_span_days_test failed");
    $finish;
  end

  // offer one item, hold it until taken, then idle for a drawn number of cycles
  task automatic send_span(input logic [idsd_pkg::YearW-1:0] sy,
                           input logic [idsd_pkg::MonthW-1:0] sm,
                           input logic [idsd_pkg::DayW-1:0] sd, input logic eg,
                           input logic [idsd_pkg::YearW-1:0] ey,
                           input logic [idsd_pkg::MonthW-1:0] em,
                           input logic [idsd_pkg::DayW-1:0] ed);
    int unsigned gap;
    in_valid    <= 1'b1;
    start_year  <= sy;
    start_month <= sm;
    start_day   <= sd;
    end_given   <= eg;
    end_year    <= ey;
    end_month   <= em;
    end_day     <= ed;
    do @(negedge clk); while (!in_ready);
    sb.note_dates(sy, sm, sd, eg, ey, em, ed);
    @(posedge clk);
    items_sent++;
    gap = ((items_sent / 120) % 4 == 2) ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic pick_date(input int unsigned y_lo, input int unsigned y_hi,
                           output logic [idsd_pkg::YearW-1:0] y,
                           output logic [idsd_pkg::MonthW-1:0] m,
                           output logic [idsd_pkg::DayW-1:0] d);
    int unsigned yy, mm, dd;
    yy = $urandom_range(y_lo, y_hi);
    mm = $urandom_range(1, 12);
    dd = $urandom_range(1, days_in_month(yy, mm));
    y = yy[idsd_pkg::YearW-1:0];
    m = mm[idsd_pkg::MonthW-1:0];
    d = dd[idsd_pkg::DayW-1:0];
  endtask

  task automatic send_random_span();
    logic [idsd_pkg::YearW-1:0]  sy, ey, ty;
    logic [idsd_pkg::MonthW-1:0] sm, em, tm;
    logic [idsd_pkg::DayW-1:0]   sd, ed, td;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      // nearby dates, sometimes in the wrong order
      pick_date(1, 9997, sy, sm, sd);
      pick_date(sy, sy + $urandom_range(0, 2), ey, em, ed);
      if ($urandom_range(0, 3) == 0) begin
        ty = sy; tm = sm; td = sd;
        sy = ey; sm = em; sd = ed;
        ey = ty; em = tm; ed = td;
      end
      send_span(sy, sm, sd, 1'b1, ey, em, ed);
    end else if (kind < 55) begin
      pick_date(0, 16383, sy, sm, sd);
      send_span(sy, sm, sd, 1'b0, rand_year(0, 16383), rand_month(0, 15),
                rand_day(0, 31));
    end else if (kind < 85) begin
      send_span(rand_year(0, 16383), rand_month(0, 15), rand_day(0, 31),
                rand_bit(), rand_year(0, 16383), rand_month(0, 15),
                rand_day(0, 31));
    end else begin
      // very long spans, some past the count limit
      pick_date(0, 500, sy, sm, sd);
      pick_date(9500, 16383, ey, em, ed);
      send_span(sy, sm, sd, 1'b1, ey, em, ed);
    end
  endtask

  initial begin : stimulus
    int unsigned n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_span(2000, idsd_pkg::MonJan, 1, 1'b0, 0, 0, 0);
    send_span(2024, idsd_pkg::MonFeb, 10, 1'b0, 0, 0, 0);
    send_span(1900, idsd_pkg::MonFeb, 1, 1'b0, 0, 0, 0);
    send_span(2000, idsd_pkg::MonFeb, 1, 1'b0, 0, 0, 0);
    send_span(0, idsd_pkg::MonFeb, 1, 1'b0, 0, 0, 0);
    send_span(2023, 4'd4, 15, 1'b0, 0, 0, 0);
    send_span(2023, idsd_pkg::MonDec, 1, 1'b0, 1234, 4'd5, 6);
    send_span(2023, idsd_pkg::MonMar, 5, 1'b1, 2023, idsd_pkg::MonMar, 5);
    send_span(2023, idsd_pkg::MonMar, 6, 1'b1, 2023, idsd_pkg::MonMar, 5);
    send_span(1, idsd_pkg::MonJan, 1, 1'b1, 9999, idsd_pkg::MonDec, 31);
    send_span(9999, idsd_pkg::MonDec, 31, 1'b1, 1, idsd_pkg::MonJan, 1);
    send_span(0, idsd_pkg::MonJan, 1, 1'b1, 16383, idsd_pkg::MonDec, 31);
    send_span(2021, 4'd0, 0, 1'b1, 2021, 4'd15, 31);
    send_span(2021, idsd_pkg::MonFeb, 31, 1'b1, 2021, idsd_pkg::MonMar, 3);
    send_span(16383, 4'd15, 31, 1'b0, 16383, 4'd15, 31);
    send_span(16383, 4'd15, 31, 1'b1, 16383, 4'd15, 31);
    send_span(2100, idsd_pkg::MonFeb, 28, 1'b1, 2100, idsd_pkg::MonMar, 1);
    send_span(2024, idsd_pkg::MonFeb, 28, 1'b1, 2024, idsd_pkg::MonMar, 1);
    send_span(1999, idsd_pkg::MonDec, 31, 1'b1, 2000, idsd_pkg::MonJan, 1);
    send_span(0, 4'd0, 0, 1'b1, 0, 4'd0, 0);

    for (n = 0; n < 1080; n++) send_random_span();
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("inclusive_date_span_days_test passed");
    end else begin
      $display("inclusive_date_span_days_test failed");
    end
    $finish;
  end

  initial begin : drain
    int unsigned hold, taken;
    taken = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      // two long stalls so the pipeline fills and backs up the input
      if (taken == 40 || taken == 700) hold = 120;
      else if ((taken / 150) % 3 == 1) hold = 0;
      else hold = $urandom_range(0, 14);
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      sb.check_span(day_count, order_error);
      taken++;
      @(posedge clk);
    end
  end

endmodule

`default_nettype wire
